// ===== sv/rrps_pkg.sv =====
// Shared types, constants and helper functions of the round-robin process scheduler.
`default_nettype none

package rrps_pkg;

    // Size of the process table and the widths that follow from it.
    localparam int MAX_PROCESSES = 64;
    localparam int PID_W         = $clog2(MAX_PROCESSES);
    localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);
    localparam int ST_W          = 3;

    // Fixed widths of the channel fields.
    localparam int FLD_CMD_W = 2;
    localparam int FLD_PID_W = 6;
    localparam int FLD_ST_W  = 3;
    localparam int FLD_ERR_W = 2;

    // Width used to compare a channel process number against the count.
    localparam int CMP_W  = (CNT_W > FLD_PID_W) ? CNT_W : FLD_PID_W;
    localparam int WIDE_W = PID_W + FLD_PID_W;

    typedef enum logic [FLD_CMD_W-1:0] {
        CMD_CREATE     = 2'd0,
        CMD_SET_STATUS = 2'd1,
        CMD_SET_NEXT   = 2'd2,
        CMD_YIELD      = 2'd3
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_SETUP      = 3'd0,
        ST_ACTIVE     = 3'd1,
        ST_INACTIVE   = 3'd2,
        ST_SLEEP      = 3'd3,
        ST_WAITING    = 3'd4,
        ST_WAIT_DEATH = 3'd5,
        ST_DEAD       = 3'd6
    } t_status;

    typedef enum logic [FLD_ERR_W-1:0] {
        ERR_OK       = 2'd0,
        ERR_FULL     = 2'd1,
        ERR_UNKNOWN  = 2'd2,
        ERR_NO_READY = 2'd3
    } t_err;

    // One command as it enters the sequencer.
    typedef struct packed {
        logic [FLD_CMD_W-1:0] command;
        logic [FLD_PID_W-1:0] target_pid;
        logic [FLD_ST_W-1:0]  new_status;
    } t_cmd_item;

    // One result as it leaves the sequencer.
    typedef struct packed {
        logic                 switched;
        logic [FLD_PID_W-1:0] current_pid;
        logic [FLD_PID_W-1:0] previous_pid;
        logic [FLD_PID_W-1:0] created_pid;
        logic [FLD_ERR_W-1:0] error_code;
    } t_result;

    // A status code that the scan may pick.
    function automatic logic is_runnable(input logic [ST_W-1:0] s);
        return (s == ST_ACTIVE) || (s == ST_INACTIVE) || (s == ST_SLEEP);
    endfunction

    // Next process number in round-robin order, wrapping at the count.
    function automatic logic [PID_W-1:0] wrap_next(input logic [PID_W-1:0] p,
                                                   input logic [CNT_W-1:0] count);
        logic [CNT_W-1:0] inc;
        inc = CNT_W'(p) + CNT_W'(1);
        return (inc == count) ? '0 : inc[PID_W-1:0];
    endfunction

    // Internal process number shown on a channel field, low bits only.
    function automatic logic [FLD_PID_W-1:0] to_field(input logic [PID_W-1:0] p);
        logic [WIDE_W-1:0] wide;
        wide = WIDE_W'(p);
        return wide[FLD_PID_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/rrps_if.sv =====
// Command and result channel interfaces of the round-robin process scheduler.
`default_nettype none

interface rrps_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [rrps_pkg::FLD_CMD_W-1:0] command;
    logic [rrps_pkg::FLD_PID_W-1:0] target_pid;
    logic [rrps_pkg::FLD_ST_W-1:0]  new_status;

    modport source (output valid, command, target_pid, new_status, input ready);
    modport sink   (input valid, command, target_pid, new_status, output ready);
endinterface

interface rrps_res_if;
    logic                           valid;
    logic                           ready;
    logic                           switched;
    logic [rrps_pkg::FLD_PID_W-1:0] current_pid;
    logic [rrps_pkg::FLD_PID_W-1:0] previous_pid;
    logic [rrps_pkg::FLD_PID_W-1:0] created_pid;
    logic [rrps_pkg::FLD_ERR_W-1:0] error_code;

    modport source (output valid, switched, current_pid, previous_pid, created_pid,
                    error_code, input ready);
    modport sink   (input valid, switched, current_pid, previous_pid, created_pid,
                    error_code, output ready);
endinterface

`default_nettype wire

// ===== sv/rrps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rrps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/rrps_seq.sv =====
// Command sequencer: read-modify-write of the process table and the scheduler registers.
`default_nettype none

module rrps_seq (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cmd_valid,
    output logic                            o_cmd_ready,
    input  wire rrps_pkg::t_cmd_item        i_cmd,
    input  wire logic                       i_res_free,
    output logic                            o_res_load,
    output rrps_pkg::t_result               o_res,
    output logic                            o_mem_we,
    output logic [rrps_pkg::PID_W-1:0]      o_mem_waddr,
    output logic [rrps_pkg::ST_W-1:0]       o_mem_wdata,
    output logic                            o_mem_re,
    output logic [rrps_pkg::PID_W-1:0]      o_mem_raddr,
    input  wire logic [rrps_pkg::ST_W-1:0]  i_mem_rdata
);
    import rrps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OLD,
        S_SCAN,
        S_WR_PREV,
        S_WR_NEXT,
        S_FIN
    } t_state;

    // Control state.
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PID_W-1:0] r_running, n_running;
    logic [PID_W-1:0] r_fpid, n_fpid;
    logic             r_fvalid, n_fvalid;
    logic             r_zero_written, n_zero_written;

    // Per-command working registers.
    logic [PID_W-1:0] r_prev, n_prev;
    logic [PID_W-1:0] r_created, n_created;
    logic [PID_W-1:0] r_next, n_next;
    logic [PID_W-1:0] r_cur, n_cur;
    logic [PID_W-1:0] r_scan, n_scan;
    logic [CNT_W-1:0] r_left, n_left;
    logic [ST_W-1:0]  r_old, n_old;
    logic             r_sw, n_sw;
    t_err             r_err, n_err;
    logic             r_rd_zero, n_rd_zero;

    logic [ST_W-1:0]  rd_status;
    logic             tgt_known;
    logic [PID_W-1:0] tgt_pid;
    logic [PID_W-1:0] start_pid;

    // Entry zero reads as active until the table first writes it.
    assign rd_status = r_rd_zero ? ST_ACTIVE : i_mem_rdata;
    assign tgt_known = CMP_W'(i_cmd.target_pid) < CMP_W'(r_count);
    assign tgt_pid   = PID_W'(i_cmd.target_pid);
    assign start_pid = wrap_next(r_running, r_count);

    assign o_cmd_ready = (r_state == S_IDLE);

    // Result as it goes to the output register.
    assign o_res.switched     = r_sw;
    assign o_res.current_pid  = to_field(r_running);
    assign o_res.previous_pid = to_field(r_prev);
    assign o_res.created_pid  = to_field(r_created);
    assign o_res.error_code   = r_err;

    // Next-state and table access logic.
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_running      = r_running;
        n_fpid         = r_fpid;
        n_fvalid       = r_fvalid;
        n_prev         = r_prev;
        n_created      = r_created;
        n_next         = r_next;
        n_cur          = r_cur;
        n_scan         = r_scan;
        n_left         = r_left;
        n_old          = r_old;
        n_sw           = r_sw;
        n_err          = r_err;
        n_rd_zero      = r_rd_zero;
        o_mem_we       = 1'b0;
        o_mem_waddr    = r_running;
        o_mem_wdata    = ST_SETUP;
        o_mem_re       = 1'b0;
        o_mem_raddr    = r_running;
        o_res_load     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_prev    = r_running;
                    n_sw      = 1'b0;
                    n_created = '0;
                    n_err     = ERR_OK;
                    n_state   = S_FIN;
                    unique case (t_cmd'(i_cmd.command))
                        CMD_CREATE: begin
                            if (r_count == CNT_W'(MAX_PROCESSES)) begin
                                n_err = ERR_FULL;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_count[PID_W-1:0];
                                o_mem_wdata = ST_SETUP;
                                n_created   = r_count[PID_W-1:0];
                                n_count     = r_count + CNT_W'(1);
                            end
                        end
                        CMD_SET_STATUS: begin
                            if (!tgt_known) begin
                                n_err = ERR_UNKNOWN;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = tgt_pid;
                                o_mem_wdata = i_cmd.new_status;
                            end
                        end
                        CMD_SET_NEXT: begin
                            if (!tgt_known) begin
                                n_err    = ERR_UNKNOWN;
                                n_fvalid = 1'b0;
                            end else begin
                                n_fpid   = tgt_pid;
                                n_fvalid = 1'b1;
                            end
                        end
                        CMD_YIELD: begin
                            // Fetch the status of the running process first.
                            o_mem_re    = 1'b1;
                            o_mem_raddr = r_running;
                            n_rd_zero   = (r_running == '0) && !r_zero_written;
                            n_state     = S_OLD;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_OLD: begin
                n_old = rd_status;
                if (r_fvalid) begin
                    // An armed override wins and is consumed.
                    n_fvalid = 1'b0;
                    n_next   = r_fpid;
                    n_state  = (r_fpid == r_running) ? S_FIN : S_WR_PREV;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = start_pid;
                    n_rd_zero   = (start_pid == '0) && !r_zero_written;
                    n_cur       = start_pid;
                    n_scan      = wrap_next(start_pid, r_count);
                    n_left      = r_count - CNT_W'(1);
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (is_runnable(rd_status)) begin
                    n_next  = r_cur;
                    n_state = (r_cur == r_running) ? S_FIN : S_WR_PREV;
                end else if (r_left == '0) begin
                    n_err   = ERR_NO_READY;
                    n_state = S_FIN;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_scan;
                    n_rd_zero   = (r_scan == '0) && !r_zero_written;
                    n_cur       = r_scan;
                    n_scan      = wrap_next(r_scan, r_count);
                    n_left      = r_left - CNT_W'(1);
                end
            end
            S_WR_PREV: begin
                // A waiting process keeps its status across the switch.
                if (r_old != ST_WAITING) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_running;
                    o_mem_wdata = (r_old == ST_WAIT_DEATH) ? ST_DEAD : ST_INACTIVE;
                end
                n_state = S_WR_NEXT;
            end
            S_WR_NEXT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_next;
                o_mem_wdata = ST_ACTIVE;
                n_running   = r_next;
                n_sw        = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (i_res_free) begin
                    o_res_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_zero_written = r_zero_written || (o_mem_we && (o_mem_waddr == '0));
    end

    // State and working registers.
    always_ff @(posedge i_clk) begin
        r_prev    <= n_prev;
        r_created <= n_created;
        r_next    <= n_next;
        r_cur     <= n_cur;
        r_scan    <= n_scan;
        r_left    <= n_left;
        r_old     <= n_old;
        r_sw      <= n_sw;
        r_err     <= n_err;
        r_rd_zero <= n_rd_zero;
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= CNT_W'(1);
            r_running      <= '0;
            r_fpid         <= '0;
            r_fvalid       <= 1'b0;
            r_zero_written <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_running      <= n_running;
            r_fpid         <= n_fpid;
            r_fvalid       <= n_fvalid;
            r_zero_written <= n_zero_written;
        end
    end

endmodule

`default_nettype wire

// ===== sv/round_robin_process_scheduler.sv =====
// Top level of the round-robin process scheduler: table RAM, sequencer and result register.
//
//   Channel   Direction  Payload
//   i_cmd     in         command, target_pid, new_status
//   o_res     out        switched, current_pid, previous_pid, created_pid, error_code
//
// Create, set status and set next go straight from the transfer to the finish state.
// A yield reads the running entry, then the round-robin scan reads one entry per cycle, as
// the RAM has one read port; a switch writes the new entry and, if not waiting, the old.
// The command side takes a new transfer while a result still waits in the output register.
// Reset is synchronous; entry zero reads as active until it is first written.
`default_nettype none

module round_robin_process_scheduler (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rrps_cmd_if.sink    i_cmd,
    rrps_res_if.source  o_res
);
    import rrps_pkg::*;

    t_cmd_item        cmd_item;
    t_result          seq_res;
    logic             res_load;
    logic             res_free;
    logic             mem_we;
    logic [PID_W-1:0] mem_waddr;
    logic [ST_W-1:0]  mem_wdata;
    logic             mem_re;
    logic [PID_W-1:0] mem_raddr;
    logic [ST_W-1:0]  mem_rdata;

    logic             r_out_valid;
    t_result          r_out;

    assign cmd_item.command    = i_cmd.command;
    assign cmd_item.target_pid = i_cmd.target_pid;
    assign cmd_item.new_status = i_cmd.new_status;

    // Process state table.
    rrps_ram #(
        .WIDTH (ST_W),
        .DEPTH (MAX_PROCESSES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Command sequencer.
    rrps_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (i_cmd.ready),
        .i_cmd       (cmd_item),
        .i_res_free  (res_free),
        .o_res_load  (res_load),
        .o_res       (seq_res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // Output register, free when empty or when its result transfers.
    assign res_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= seq_res;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.switched     = r_out.switched;
    assign o_res.current_pid  = r_out.current_pid;
    assign o_res.previous_pid = r_out.previous_pid;
    assign o_res.created_pid  = r_out.created_pid;
    assign o_res.error_code   = r_out.error_code;

endmodule

`default_nettype wire

// ===== sv/rrps_checker.sv =====
// Port-level checks of the round-robin process scheduler and their binding.
`default_nettype none

module rrps_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_res_valid,
    input wire logic                           i_res_ready,
    input wire logic                           i_switched,
    input wire logic [rrps_pkg::FLD_PID_W-1:0] i_current_pid,
    input wire logic [rrps_pkg::FLD_PID_W-1:0] i_previous_pid,
    input wire logic [rrps_pkg::FLD_PID_W-1:0] i_created_pid,
    input wire logic [rrps_pkg::FLD_ERR_W-1:0] i_error_code
);
    import rrps_pkg::*;

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_switched)
            && $stable(i_current_pid) && $stable(i_previous_pid)
            && $stable(i_created_pid) && $stable(i_error_code))
        else $error("result changed while stalled");

    // A switch is error free and moves to another process.
    a_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_switched |-> (i_error_code == ERR_OK)
            && (i_current_pid != i_previous_pid))
        else $error("bad switch result");

    // Without a switch the running process stays the same.
    a_stay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_switched |-> i_current_pid == i_previous_pid)
        else $error("running process moved without a switch");

    // A created number comes only from a successful create.
    a_create: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_created_pid != '0) |-> (i_error_code == ERR_OK) && !i_switched)
        else $error("created number on a failed or switching command");

endmodule

bind round_robin_process_scheduler rrps_checker u_rrps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_switched     (o_res.switched),
    .i_current_pid  (o_res.current_pid),
    .i_previous_pid (o_res.previous_pid),
    .i_created_pid  (o_res.created_pid),
    .i_error_code   (o_res.error_code)
);

`default_nettype wire
